/* design/fw2d_pkg.sv */
// Package: shared widths, codes and sequencer state type for the 2-D Fenwick rectangle-sum block.
`default_nettype none

package fw2d_pkg;

    // Default grid side.
    localparam int SIDE_DEF = 16;

    // Fixed field widths.
    localparam int COORD_W = 4;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 32;

    // Request action codes.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_LOAD,
        ST_Q_RUN,
        ST_Q_DRAIN,
        ST_Q_DONE
    } t_state;

endpackage

`default_nettype wire

/* design/fw2d_if.sv */
// Interfaces: request and response channels of the 2-D Fenwick rectangle-sum block.
`default_nettype none

interface fw2d_req_if;
    import fw2d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [COORD_W-1:0]        x_low;
    logic [COORD_W-1:0]        y_low;
    logic [COORD_W-1:0]        x_high;
    logic [COORD_W-1:0]        y_high;
    logic signed [VALUE_W-1:0] value;
    logic                      final_item;

    modport source (
        output valid, action, x_low, y_low, x_high, y_high, value, final_item,
        input  ready
    );
    modport sink (
        input  valid, action, x_low, y_low, x_high, y_high, value, final_item,
        output ready
    );
endinterface

interface fw2d_rsp_if;
    import fw2d_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] rect_sum;
    logic                    batch_end;

    modport source (output valid, rect_sum, batch_end, input ready);
    modport sink   (input  valid, rect_sum, batch_end, output ready);
endinterface

`default_nettype wire

/* design/fw2d_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module fw2d_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/fenwick_2d_rect_sum.sv */
// Top level: 2-D Fenwick tree of running sums with point add and rectangle-sum query.
//
//  channel  | dir | payload                                        | per request
//  ---------+-----+------------------------------------------------+-------------------
//  i_req    | in  | action, x_low, y_low, x_high, y_high, value,   | add or query
//           |     | final_item                                     |
//  o_rsp    | out | rect_sum, batch_end                            | one per query only
//
// An add reads and then writes each touched cell, chain_x*chain_y cells with
// chains of at most log2(SIDE)+1 cells; a query has a load step per prefix-sum
// term, one read per cell over the four prefix sums, then a drain and a done step.
// The single read port of the cell memory serializes these reads. After reset a
// clearing pass over all SIDE*SIDE cells zeroes the memory with i_req.ready low. A new request is taken while
// a result waits in the output register; a query waits for that register before finishing.
`default_nettype none

module fenwick_2d_rect_sum #(
    parameter int SIDE = fw2d_pkg::SIDE_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fw2d_req_if.sink   i_req,
    fw2d_rsp_if.source o_rsp
);
    import fw2d_pkg::*;

    localparam int IW    = $clog2(SIDE + 1);
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);

    // Lowest set bit of a tree index
    function automatic logic [IW-1:0] lowbit(input logic [IW-1:0] v);
        return v & (~v + IW'(1));
    endfunction

    // Saturated query edge, plus one
    function automatic logic [IW-1:0] bound_next(input logic [COORD_W-1:0] e);
        if (int'(e) > SIDE - 1) begin
            return IW'(SIDE);
        end
        return IW'(int'(e) + 1);
    endfunction

    // Flat address of one-based cell (i, j)
    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] i, input logic [IW-1:0] j);
        return AW'((int'(i) - 1) * SIDE + int'(j) - 1);
    endfunction

    t_state r_state, n_state;

    logic [AW-1:0]    r_clr_addr;
    logic [IW-1:0]    r_i, r_j, r_j0;
    logic [IW-1:0]    r_x1, r_y1, r_x2, r_y2;
    logic [1:0]       r_term;
    logic [SUM_W-1:0] r_val;
    logic [SUM_W-1:0] r_acc;
    logic             r_final;
    logic             r_rd_vld;
    logic             r_rd_neg;
    logic             r_out_vld;
    logic [SUM_W-1:0] r_out_sum;
    logic             r_out_end;

    logic             req_take;
    logic             add_in_grid;
    logic             out_free;
    logic [IW:0]      add_nj, add_ni;
    logic             add_j_end, add_i_end;
    logic [IW-1:0]    q_nj, q_ni;
    logic [IW-1:0]    term_px, term_py;
    logic             term_neg, term_empty;
    logic             last_term;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [SUM_W-1:0] ram_wdata, ram_rdata;
    logic             q_issue;

    fw2d_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SUM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake status
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign add_in_grid = (int'(i_req.x_low) < SIDE) && (int'(i_req.y_low) < SIDE);
    assign out_free    = !r_out_vld || o_rsp.ready;

    // Index chain steps: upward for add, downward for query
    always_comb begin
        add_nj    = {1'b0, r_j} + {1'b0, lowbit(r_j)};
        add_ni    = {1'b0, r_i} + {1'b0, lowbit(r_i)};
        add_j_end = add_nj > (IW + 1)'(SIDE);
        add_i_end = add_ni > (IW + 1)'(SIDE);
        q_nj      = r_j - lowbit(r_j);
        q_ni      = r_i - lowbit(r_i);
        // Terms: (x2,y2)+ (x2,y1)- (x1,y2)- (x1,y1)+
        term_px    = r_term[1] ? r_x1 : r_x2;
        term_py    = r_term[0] ? r_y1 : r_y2;
        term_neg   = r_term[1] ^ r_term[0];
        term_empty = (term_px == '0) || (term_py == '0);
        last_term  = (r_term == 2'd3);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_take) begin
                    if (i_req.action == ACT_QUERY) n_state = ST_Q_LOAD;
                    else if (add_in_grid)          n_state = ST_ADD_RD;
                end
            end
            ST_ADD_RD: n_state = ST_ADD_WR;
            ST_ADD_WR: begin
                if (!add_j_end || !add_i_end) n_state = ST_ADD_RD;
                else                          n_state = ST_IDLE;
            end
            ST_Q_LOAD: begin
                if (!term_empty)    n_state = ST_Q_RUN;
                else if (last_term) n_state = ST_Q_DRAIN;
            end
            ST_Q_RUN: begin
                if (q_nj == '0 && q_ni == '0) begin
                    n_state = last_term ? ST_Q_DRAIN : ST_Q_LOAD;
                end
            end
            ST_Q_DRAIN: n_state = ST_Q_DONE;
            ST_Q_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory controls; the sequencer never reads and writes in one cycle
    always_comb begin
        q_issue   = (r_state == ST_Q_RUN);
        ram_re    = q_issue || (r_state == ST_ADD_RD);
        ram_raddr = cell_addr(r_i, r_j);
        ram_we    = 1'b0;
        ram_waddr = cell_addr(r_i, r_j);
        ram_wdata = ram_rdata + r_val;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == ST_ADD_WR) begin
            ram_we = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= q_issue;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (r_state == ST_Q_DONE && out_free) r_out_vld <= 1'b1;
            else if (o_rsp.ready)                 r_out_vld <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Accumulate read data in the cycle after each query read
        if (r_rd_vld) begin
            r_acc <= r_rd_neg ? (r_acc - ram_rdata) : (r_acc + ram_rdata);
        end
        r_rd_neg <= term_neg;

        unique case (r_state)
            ST_IDLE: begin
                if (req_take) begin
                    r_i     <= IW'(int'(i_req.x_low) + 1);
                    r_j     <= IW'(int'(i_req.y_low) + 1);
                    r_j0    <= IW'(int'(i_req.y_low) + 1);
                    r_val   <= {{(SUM_W - VALUE_W){i_req.value[VALUE_W-1]}}, i_req.value};
                    r_x1    <= IW'(int'(bound_next(i_req.x_low)) - 1);
                    r_y1    <= IW'(int'(bound_next(i_req.y_low)) - 1);
                    r_x2    <= bound_next(i_req.x_high);
                    r_y2    <= bound_next(i_req.y_high);
                    r_term  <= 2'd0;
                    r_acc   <= '0;
                    r_final <= i_req.final_item;
                end
            end
            ST_ADD_WR: begin
                if (!add_j_end) begin
                    r_j <= add_nj[IW-1:0];
                end else begin
                    r_i <= add_ni[IW-1:0];
                    r_j <= r_j0;
                end
            end
            ST_Q_LOAD: begin
                if (term_empty) begin
                    r_term <= r_term + 2'd1;
                end else begin
                    r_i  <= term_px;
                    r_j  <= term_py;
                    r_j0 <= term_py;
                end
            end
            ST_Q_RUN: begin
                if (q_nj != '0) begin
                    r_j <= q_nj;
                end else if (q_ni != '0) begin
                    r_i <= q_ni;
                    r_j <= r_j0;
                end else begin
                    r_term <= r_term + 2'd1;
                end
            end
            ST_Q_DONE: begin
                if (out_free) begin
                    r_out_sum <= r_acc;
                    r_out_end <= r_final;
                end
            end
            default: begin
            end
        endcase
    end

    // Response channel
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.rect_sum  = r_out_sum;
    assign o_rsp.batch_end = r_out_end;

endmodule

`default_nettype wire

/* design/fw2d_chk.sv */
// Checker on the top-level ports of the 2-D Fenwick block, with its bind statement.
`default_nettype none

module fw2d_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_req_action,
    input wire logic                          o_rsp_valid,
    input wire logic                          o_rsp_ready,
    input wire logic [fw2d_pkg::SUM_W-1:0]    o_rsp_rect_sum,
    input wire logic                          o_rsp_batch_end
);
    import fw2d_pkg::*;

    logic req_take;
    assign req_take = i_req_valid && i_req_ready;

    // Reset drops the response and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && !i_req_ready)
        else $error("response valid or request ready right after reset");

    // No request yields a response in the very next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take && !o_rsp_valid |=> !o_rsp_valid)
        else $error("response appeared one cycle after a request");

    // A query keeps the block busy past its acceptance
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take && (i_req_action == ACT_QUERY) |=> !i_req_ready)
        else $error("ready stayed high after a query was taken");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=>
            o_rsp_valid && $stable(o_rsp_rect_sum) && $stable(o_rsp_batch_end))
        else $error("stalled response changed");

endmodule

bind fenwick_2d_rect_sum fw2d_chk u_fw2d_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_action    (i_req.action),
    .o_rsp_valid     (o_rsp.valid),
    .o_rsp_ready     (o_rsp.ready),
    .o_rsp_rect_sum  (o_rsp.rect_sum),
    .o_rsp_batch_end (o_rsp.batch_end)
);

`default_nettype wire
